### design/rsamx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RSA modular exponentiation block.
// No dependencies; used by rsamx_modadd, rsamx_seq and the top level.

package rsamx_pkg;

    // Configuration register index width and register map
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PUB_EXP = 2'd0,
        REG_PRV_EXP = 2'd1,
        REG_MODULUS = 2'd2
    } t_cfg_idx;

    // Command codes
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // Control for the shared modular add/double unit
    typedef struct packed {
        logic dbl;     // shift running value left by one
        logic add_en;  // add the addend operand
    } t_unit_ctl;

endpackage

### design/rsa_modular_exponentiation.sv
`timescale 1ns / 1ps
// RSA modular exponentiation, right-to-left square-and-multiply.
// Top level: config registers, sequencer and shared modular step unit.
//
// Usage:
//   Config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high
//   (0 public exponent, 1 private exponent, 2 modulus). Write only while idle.
//   Item in: accepted on a rising edge with start high and busy low.
//   i_command selects encrypt (public exponent) or decrypt (private exponent).
//   Result: o_result_value is valid for exactly one cycle with o_done high.
//   Sequence: the operand is first reduced bit by bit; then, per exponent bit
//   up to the highest set one, a decision step and a square, preceded by a
//   multiply when the bit is set. A modular multiply takes one doubling step
//   per multiplier bit plus one add step per set multiplier bit. The square
//   after the highest set bit is skipped and a final decision step ends the
//   item; a zero exponent goes from the reduction straight to that step. The
//   strobe comes in the same cycle as busy falls.
//   Modulus below two answers 0 on the cycle after start.
//   One item at a time; the next one can be accepted in the strobe cycle.
//   Reset clears the sequencer and loads exponents 0 and modulus 2.
//   The receiver cannot stall; o_done is a one-cycle strobe.

module rsa_modular_exponentiation #(
    parameter int MOD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rsamx_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [MOD_WIDTH-1:0]            i_cfg_data,
    input  logic                            start,
    input  logic                            i_command,
    input  logic [MOD_WIDTH-1:0]            i_operand_value,
    output logic                            busy,
    output logic                            o_done,
    output logic [MOD_WIDTH-1:0]            o_result_value
);

    localparam logic [MOD_WIDTH-1:0] MOD_RESET = {{(MOD_WIDTH-2){1'b0}}, 2'b10};

    logic [MOD_WIDTH-1:0] r_pub_exp;
    logic [MOD_WIDTH-1:0] r_prv_exp;
    logic [MOD_WIDTH-1:0] r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_exp <= '0;
            r_prv_exp <= '0;
            r_modulus <= MOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsamx_pkg::REG_PUB_EXP: r_pub_exp <= i_cfg_data;
                rsamx_pkg::REG_PRV_EXP: r_prv_exp <= i_cfg_data;
                rsamx_pkg::REG_MODULUS: r_modulus <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                 w_start;
    logic [MOD_WIDTH-1:0] w_exp;
    rsamx_pkg::t_unit_ctl w_ctl;
    logic [MOD_WIDTH-1:0] w_acc;
    logic [MOD_WIDTH-1:0] w_addend;
    logic [MOD_WIDTH-1:0] w_mod;
    logic [MOD_WIDTH-1:0] w_unit_res;

    assign w_start = start && !busy;
    assign w_exp   = (i_command == rsamx_pkg::CMD_DECRYPT) ? r_prv_exp : r_pub_exp;

    rsamx_seq #(
        .WIDTH (MOD_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_exp      (w_exp),
        .i_mod      (r_modulus),
        .i_operand  (i_operand_value),
        .i_unit_res (w_unit_res),
        .o_ctl      (w_ctl),
        .o_acc      (w_acc),
        .o_addend   (w_addend),
        .o_mod      (w_mod),
        .o_busy     (busy),
        .o_done     (o_done),
        .o_result   (o_result_value)
    );

    rsamx_modadd #(
        .WIDTH (MOD_WIDTH)
    ) u_modadd (
        .i_ctl    (w_ctl),
        .i_acc    (w_acc),
        .i_addend (w_addend),
        .i_mod    (w_mod),
        .o_res    (w_unit_res)
    );

    // Finishing an item always issues its result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result strobe");

    // A result is only issued from idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item either starts work or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither started nor answered");

endmodule

### design/rsamx_modadd.sv
`timescale 1ns / 1ps
// Shared modular step unit: res = ((dbl ? 2*acc : acc) + (add_en ? addend : 0)) mod n.
// Needs acc < n and addend < n (or addend <= 1 with dbl). Uses rsamx_pkg.

module rsamx_modadd #(
    parameter int WIDTH = 16
) (
    input  rsamx_pkg::t_unit_ctl i_ctl,
    input  logic [WIDTH-1:0]     i_acc,
    input  logic [WIDTH-1:0]     i_addend,
    input  logic [WIDTH-1:0]     i_mod,
    output logic [WIDTH-1:0]     o_res
);

    logic [WIDTH:0] w_base;
    logic [WIDTH:0] w_add;
    logic [WIDTH:0] w_sum;
    logic [WIDTH:0] w_diff;

    always_comb begin
        w_base = i_ctl.dbl ? {i_acc, 1'b0} : {1'b0, i_acc};
        w_add  = i_ctl.add_en ? {1'b0, i_addend} : '0;
        w_sum  = w_base + w_add;
        w_diff = w_sum - {1'b0, i_mod};
        // sum stays below 2n, so one conditional subtract reduces it
        if (w_sum >= {1'b0, i_mod}) begin
            o_res = w_diff[WIDTH-1:0];
        end else begin
            o_res = w_sum[WIDTH-1:0];
        end
    end

endmodule

### design/rsamx_seq.sv
`timescale 1ns / 1ps
// Sequencer for square-and-multiply: operand reduction, then interleaved
// double/add modular multiplies on one shared unit. Uses rsamx_pkg.

module rsamx_seq #(
    parameter int WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIDTH-1:0]     i_exp,
    input  logic [WIDTH-1:0]     i_mod,
    input  logic [WIDTH-1:0]     i_operand,
    input  logic [WIDTH-1:0]     i_unit_res,
    output rsamx_pkg::t_unit_ctl o_ctl,
    output logic [WIDTH-1:0]     o_acc,
    output logic [WIDTH-1:0]     o_addend,
    output logic [WIDTH-1:0]     o_mod,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [WIDTH-1:0]     o_result
);

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WIDTH - 1);
    localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_NEXT   = 5'b00100,
        S_DBL    = 5'b01000,
        S_ADD    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic r_done, n_done;
    logic [WIDTH-1:0] r_result, n_result;
    logic [WIDTH-1:0] r_mod, n_mod;
    logic [WIDTH-1:0] r_exp, n_exp;      // remaining exponent bits
    logic [WIDTH-1:0] r_base, n_base;
    logic [WIDTH-1:0] r_accum, n_accum;
    logic [WIDTH-1:0] r_mr, n_mr;        // running remainder
    logic [WIDTH-1:0] r_mb, n_mb;        // multiplier bits, msb first
    logic [WIDTH-1:0] r_ma, n_ma;        // multiplicand
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic r_sq, n_sq;                    // current multiply is the squaring

    always_comb begin
        n_state  = r_state;
        n_done   = 1'b0;
        n_result = r_result;
        n_mod    = r_mod;
        n_exp    = r_exp;
        n_base   = r_base;
        n_accum  = r_accum;
        n_mr     = r_mr;
        n_mb     = r_mb;
        n_ma     = r_ma;
        n_cnt    = r_cnt;
        n_sq     = r_sq;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_start) begin
                    if (i_mod[WIDTH-1:1] == '0) begin
                        // modulus 0 or 1: everything is congruent to 0
                        n_done   = 1'b1;
                        n_result = '0;
                    end else begin
                        n_mod   = i_mod;
                        n_exp   = i_exp;
                        n_accum = ONE;
                        n_mr    = '0;
                        n_mb    = i_operand;
                        n_cnt   = CNT_MAX;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                n_mr = i_unit_res;
                n_mb = r_mb << 1;
                if (r_cnt == '0) begin
                    n_base  = i_unit_res;
                    n_state = S_NEXT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_NEXT: begin
                if (r_exp == '0) begin
                    n_done   = 1'b1;
                    n_result = r_accum;
                    n_state  = S_IDLE;
                end else begin
                    n_mr    = '0;
                    n_cnt   = CNT_MAX;
                    n_ma    = r_base;
                    n_state = S_DBL;
                    if (r_exp[0]) begin
                        n_mb = r_accum;
                        n_sq = 1'b0;
                    end else begin
                        n_mb = r_base;
                        n_sq = 1'b1;
                    end
                end
            end
            S_DBL, S_ADD: begin
                n_mr = i_unit_res;
                if (r_state == S_DBL && r_mb[WIDTH-1]) begin
                    n_state = S_ADD;
                end else begin
                    n_mb    = r_mb << 1;
                    n_state = S_DBL;
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                    end else if (!r_sq) begin
                        n_accum = i_unit_res;
                        if (r_exp[WIDTH-1:1] == '0) begin
                            // no higher bits: the last squaring is not needed
                            n_exp   = '0;
                            n_state = S_NEXT;
                        end else begin
                            n_mr  = '0;
                            n_cnt = CNT_MAX;
                            n_ma  = r_base;
                            n_mb  = r_base;
                            n_sq  = 1'b1;
                        end
                    end else begin
                        n_base  = i_unit_res;
                        n_exp   = r_exp >> 1;
                        n_state = S_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_mod    <= n_mod;
        r_exp    <= n_exp;
        r_base   <= n_base;
        r_accum  <= n_accum;
        r_mr     <= n_mr;
        r_mb     <= n_mb;
        r_ma     <= n_ma;
        r_cnt    <= n_cnt;
        r_sq     <= n_sq;
    end

    always_comb begin
        o_ctl.dbl    = (r_state == S_REDUCE) || (r_state == S_DBL);
        o_ctl.add_en = (r_state == S_REDUCE) || (r_state == S_ADD);
        o_addend     = (r_state == S_REDUCE) ? {{(WIDTH-1){1'b0}}, r_mb[WIDTH-1]} : r_ma;
    end

    assign o_acc    = r_mr;
    assign o_mod    = r_mod;
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
